/* design/isc_pkg.sv */
// Package for the indexed sequence store: sizes, operation and status codes,
// and the command that the top level broadcasts to the row of storage cells.
// No dependencies.
package isc_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 6;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [2:0] {
        MODE_CLEAR  = 3'd0,
        MODE_APPEND = 3'd1,
        MODE_INSERT = 3'd2,
        MODE_READ   = 3'd3,
        MODE_DELETE = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_RANGE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE
    } t_cell_op;

    typedef struct packed {
        t_cell_op                  op;
        logic [CMP_W-1:0]          pos;
        logic signed [DATA_W-1:0]  value;
    } t_cell_cmd;

endpackage

/* design/isc_cell.sv */
// One storage cell of the indexed sequence store: holds one element and takes
// its neighbor's value when an insert or delete shifts the row.
// Depends on isc_pkg.
module isc_cell
    import isc_pkg::*;
(
    input  logic                     i_clk,
    input  logic [CMP_W-1:0]         i_index,
    input  t_cell_cmd                i_cmd,
    input  logic signed [DATA_W-1:0] i_left,
    input  logic signed [DATA_W-1:0] i_right,
    output logic signed [DATA_W-1:0] o_data,
    output logic signed [DATA_W-1:0] o_read
);

    logic signed [DATA_W-1:0] r_data;
    logic signed [DATA_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        case (i_cmd.op)
            CELL_INSERT: begin
                if (i_index == i_cmd.pos) begin
                    n_data = i_cmd.value;
                end else if (i_index > i_cmd.pos) begin
                    n_data = i_left;
                end
            end
            CELL_DELETE: begin
                if (i_index >= i_cmd.pos) begin
                    n_data = i_right;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_read = (i_index == i_cmd.pos) ? r_data : '0;

endmodule

/* design/indexed_sequence_store_unit.sv */
// Top level of the indexed sequence store: operation decode, element count,
// result registers and the row of isc_cell storage cells.
// Depends on isc_pkg and isc_cell.
//
//   Port group        Direction  Handshake         Fields
//   request           in         start, busy       i_mode, i_position, i_item_value
//   result            out        o_valid strobe    o_read_value, o_count, o_status
//
// The row of cells shifts all elements in parallel, and the result appears on
// the cycle after acceptance. busy is always low, so a request may be accepted
// on every clock edge. Reset clears the element count and the result strobe;
// element contents are not cleared. The receiver cannot stall; each result is
// shown for exactly one cycle.
module indexed_sequence_store_unit
    import isc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [2:0]               i_mode,
    input  logic [POS_W-1:0]         i_position,
    input  logic signed [DATA_W-1:0] i_item_value,
    output logic                     o_valid,
    output logic signed [DATA_W-1:0] o_read_value,
    output logic [CNT_W-1:0]         o_count,
    output logic [1:0]               o_status
);

    logic                     accept;
    logic [CMP_W-1:0]         pos_w;
    logic [CMP_W-1:0]         cnt_w;
    logic [CMP_W-1:0]         cap_w;
    t_cell_cmd                cmd;
    t_cell_cmd                cell_cmd;
    logic [CNT_W-1:0]         n_count;
    t_status                  n_status;
    logic                     read_ok;
    logic signed [DATA_W-1:0] read_any;

    logic                     r_valid;
    logic [CNT_W-1:0]         r_count;
    logic signed [DATA_W-1:0] r_read_value;
    t_status                  r_status;

    logic signed [DATA_W-1:0] cell_data [CAPACITY];
    logic signed [DATA_W-1:0] cell_read [CAPACITY];

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign pos_w  = CMP_W'(i_position);
    assign cnt_w  = CMP_W'(r_count);
    assign cap_w  = CMP_W'(CAPACITY);

    always_comb begin
        cmd.op    = CELL_HOLD;
        cmd.pos   = pos_w;
        cmd.value = i_item_value;
        n_count   = r_count;
        n_status  = STATUS_OK;
        read_ok   = 1'b0;
        unique case (i_mode)
            MODE_CLEAR: begin
                n_count = '0;
            end
            MODE_APPEND: begin
                if (cnt_w >= cap_w) begin
                    n_status = STATUS_FULL;
                end else begin
                    cmd.op  = CELL_INSERT;
                    cmd.pos = cnt_w;
                    n_count = CNT_W'(r_count + 1'b1);
                end
            end
            MODE_INSERT: begin
                if (pos_w > cnt_w) begin
                    n_status = STATUS_RANGE;
                end else if (cnt_w >= cap_w) begin
                    n_status = STATUS_FULL;
                end else begin
                    cmd.op  = CELL_INSERT;
                    n_count = CNT_W'(r_count + 1'b1);
                end
            end
            MODE_READ: begin
                if (pos_w >= cnt_w) begin
                    n_status = STATUS_RANGE;
                end else begin
                    read_ok = 1'b1;
                end
            end
            MODE_DELETE: begin
                if (pos_w >= cnt_w) begin
                    n_status = STATUS_RANGE;
                end else begin
                    cmd.op  = CELL_DELETE;
                    n_count = CNT_W'(r_count - 1'b1);
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_comb begin
        cell_cmd = cmd;
        if (!accept) begin
            cell_cmd.op = CELL_HOLD;
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [DATA_W-1:0] left;
        logic signed [DATA_W-1:0] right;
        if (g == 0) begin : g_first
            assign left = '0;
        end else begin : g_inner_l
            assign left = cell_data[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign right = cell_data[g];
        end else begin : g_inner_r
            assign right = cell_data[g+1];
        end
        isc_cell u_cell (
            .i_clk   (i_clk),
            .i_index (CMP_W'(g)),
            .i_cmd   (cell_cmd),
            .i_left  (left),
            .i_right (right),
            .o_data  (cell_data[g]),
            .o_read  (cell_read[g])
        );
    end

    always_comb begin
        read_any = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            read_any = read_any | cell_read[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_count <= '0;
        end else begin
            r_valid <= accept;
            if (accept) begin
                r_count <= n_count;
            end
        end
        if (accept) begin
            r_read_value <= read_ok ? read_any : '0;
            r_status     <= n_status;
        end
    end

    assign o_valid      = r_valid;
    assign o_read_value = r_read_value;
    assign o_count      = r_count;
    assign o_status     = r_status;

    a_strobe_follows_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_valid == $past(accept)))
        else $error("Result strobe does not follow the accepted request.");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_count) <= cap_w)
        else $error("Element count exceeds capacity.");

    a_full_means_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_status == STATUS_FULL) |-> (CMP_W'(r_count) == cap_w))
        else $error("Full status reported while the store is not full.");

    a_error_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_status != STATUS_OK) |-> (r_read_value == '0))
        else $error("Nonzero read value with an error status.");

endmodule
